// ===== rtl/discharge_limit_ramp_macros.svh =====
// Assertion macros used by the checker file.
`ifndef DISCHARGE_LIMIT_RAMP_MACROS_SVH
`define DISCHARGE_LIMIT_RAMP_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is low.
`define DLR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define DLR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dlr_pkg.sv =====
`default_nettype none

package dlr_pkg;

    localparam int CodeW    = 8;
    localparam int ChargeW  = 10;
    localparam int LevelW   = 15;
    localparam int InDataW  = 24;
    localparam int OutDataW = 16;
    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 32;

    typedef logic [CodeW-1:0]    t_code;
    typedef logic [ChargeW-1:0]  t_charge;
    typedef logic [LevelW-1:0]   t_level;

    localparam logic [CfgAddrW-1:0] RegRampStep = 2'd0;
    localparam t_level RampStepReset = 15'd16;

    // Target limit in centi-amps over temperature and charge bands.
    function automatic t_level target_lookup(input t_code code, input t_charge charge);
        t_level lim;
        lim = '0;
        priority if (code <= 8'd10 || code > 8'd90) begin
            lim = 15'd0;
        end else if (code <= 8'd20) begin
            lim = (charge <= 10'd100) ? 15'd600 :
                  (charge <= 10'd400) ? 15'd1800 : 15'd3600;
        end else if (code <= 8'd30) begin
            lim = (charge <= 10'd100) ? 15'd3600 :
                  (charge <= 10'd400) ? 15'd6000 : 15'd9600;
        end else if (code <= 8'd50) begin
            lim = (charge <= 10'd100) ? 15'd6000 :
                  (charge <= 10'd400) ? 15'd12000 : 15'd18000;
        end else if (code <= 8'd60) begin
            lim = (charge < 10'd100) ? 15'd6000 :
                  (charge <= 10'd400) ? 15'd14400 : 15'd24000;
        end else begin
            lim = (charge < 10'd100) ? 15'd12000 :
                  (charge <= 10'd400) ? 15'd14400 : 15'd24000;
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/discharge_limit_ramp.sv =====
`default_nettype none

// Discharge current limit with ramp. Each request carries a temperature code
// (deg C plus 40) and a state of charge in per mille; a fixed band table gives
// a target in centi-amps, and one result per request reports the ramped limit.
// The first request after reset jumps straight to its target; later ones move
// the limit by ramp_step (APB register at address 0, reset 16) toward a target
// that stays latched until reached, clamping on arrival. Two register stages:
// the table lookup is registered, then the ramp update writes the result
// register. A result is valid once its request has passed both registers,
// and one request is taken every cycle while the output side keeps up.
// Write ramp_step only while no request is in flight.
module discharge_limit_ramp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] temperature_code, [17:8] charge_permille, [23:18] zero
    input  wire  [dlr_pkg::InDataW-1:0]     i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // [14:0] current_limit, [15] zero
    output logic [dlr_pkg::OutDataW-1:0]    o_m_tdata,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [dlr_pkg::CfgAddrW-1:0]    paddr,
    input  wire  [dlr_pkg::CfgDataW-1:0]    pwdata,
    output logic [dlr_pkg::CfgDataW-1:0]    prdata,
    output logic                            pready
);
    import dlr_pkg::*;

    t_level r_ramp_step;
    logic   r_s1_valid;
    t_level r_s1_target;
    logic   r_out_valid;
    t_level r_out_level;
    logic   r_started;
    logic   r_ramping;
    t_level r_level;
    t_level r_held;

    logic   s1_adv;
    logic   s_accept;
    logic   step_fire;
    t_level n_level;
    t_level n_held;
    logic   n_ramping;
    t_level held;
    logic [LevelW:0] sum_up;
    logic [LevelW:0] sum_down;

    assign pready = 1'b1;
    assign prdata = (paddr == RegRampStep) ? {{(CfgDataW-LevelW){1'b0}}, r_ramp_step} : '0;

    assign s1_adv     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign step_fire  = r_s1_valid && s1_adv;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_level};

    always_comb begin
        held      = r_ramping ? r_held : r_s1_target;
        sum_up    = {1'b0, r_level} + {1'b0, r_ramp_step};
        sum_down  = {1'b0, held} + {1'b0, r_ramp_step};
        n_level   = r_level;
        n_held    = held;
        n_ramping = r_ramping;
        if (!r_started) begin
            n_level   = r_s1_target;
            n_ramping = 1'b0;
        end else if (r_level == held) begin
            n_ramping = 1'b0;
        end else if (r_level > held) begin
            if (r_ramp_step != '0 && {1'b0, r_level} <= sum_down) begin
                n_level   = held;
                n_ramping = 1'b0;
            end else begin
                n_level   = r_level - r_ramp_step;
                n_ramping = 1'b1;
            end
        end else begin
            if (r_ramp_step != '0 && sum_up >= {1'b0, held}) begin
                n_level   = held;
                n_ramping = 1'b0;
            end else begin
                n_level   = sum_up[LevelW-1:0];
                n_ramping = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step <= RampStepReset;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_ramping   <= 1'b0;
            r_level     <= '0;
            r_held      <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == RegRampStep) begin
                r_ramp_step <= pwdata[LevelW-1:0];
            end
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (step_fire) begin
                r_started <= 1'b1;
                r_ramping <= n_ramping;
                r_level   <= n_level;
                r_held    <= n_held;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_target <= target_lookup(i_s_tdata[CodeW-1:0],
                                         i_s_tdata[CodeW+ChargeW-1:CodeW]);
        end
        if (step_fire) begin
            r_out_level <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dlr_checker.sv =====
`default_nettype none

`include "discharge_limit_ramp_macros.svh"

module dlr_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             o_m_tvalid,
    input wire                             i_m_tready,
    input wire [dlr_pkg::OutDataW-1:0]     o_m_tdata,
    input wire                             psel,
    input wire                             penable,
    input wire                             pwrite,
    input wire [dlr_pkg::CfgAddrW-1:0]     paddr,
    input wire [dlr_pkg::CfgDataW-1:0]     pwdata,
    input wire [dlr_pkg::CfgDataW-1:0]     prdata
);
    import dlr_pkg::*;

    `DLR_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `DLR_ASSERT(a_out_range, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata <= 16'd24000, "limit above table maximum")
    `DLR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")
    `DLR_ASSERT(a_step_readback, i_clk, i_rst_n, (psel && penable && pwrite && paddr == RegRampStep) ##1 (paddr == RegRampStep) |-> prdata[LevelW-1:0] == $past(pwdata[LevelW-1:0]), "ramp_step readback mismatch")

endmodule

bind discharge_limit_ramp dlr_checker u_dlr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

`default_nettype wire

// ===== dv/discharge_limit_ramp_tb.sv =====
`default_nettype none

module discharge_limit_ramp_tb;
    import dlr_pkg::*;

    // Tracks the ramped discharge limit and the queue of limits still owed by the block.
    class limit_scoreboard;
        t_level step_size;
        bit     first_seen;
        t_level ramp_pos;
        t_level latched_target;
        bit     ramp_active;
        t_level reported_limit;
        t_level limit_q[$];
        int     error_count;

        function new();
            step_size      = RampStepReset;
            first_seen     = 1'b0;
            ramp_pos       = '0;
            latched_target = '0;
            ramp_active    = 1'b0;
            reported_limit = '0;
            error_count    = 0;
        endfunction

        function void flag(string msg);
            error_count++;
            if (error_count <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void set_step(t_level value);
            step_size = value;
        endfunction

        function int pending();
            return limit_q.size();
        endfunction

        function t_level band_target(t_code code, t_charge charge);
            if (code <= 10 || code > 90) begin
                return 15'd0;
            end else if (code <= 20) begin
                return (charge <= 100) ? 15'd600 : (charge <= 400) ? 15'd1800 : 15'd3600;
            end else if (code <= 30) begin
                return (charge <= 100) ? 15'd3600 : (charge <= 400) ? 15'd6000 : 15'd9600;
            end else if (code <= 50) begin
                return (charge <= 100) ? 15'd6000 : (charge <= 400) ? 15'd12000 : 15'd18000;
            end else if (code <= 60) begin
                return (charge < 100) ? 15'd6000 : (charge <= 400) ? 15'd14400 : 15'd24000;
            end
            return (charge < 100) ? 15'd12000 : (charge <= 400) ? 15'd14400 : 15'd24000;
        endfunction

        function void note_request(t_code code, t_charge charge);
            int unsigned tgt;
            int unsigned pos;
            int unsigned stp;
            tgt = band_target(code, charge);
            pos = ramp_pos;
            stp = step_size;
            if (!first_seen) begin
                ramp_pos       = t_level'(tgt);
                reported_limit = t_level'(tgt);
                first_seen     = 1'b1;
            end else begin
                if (!ramp_active) begin
                    latched_target = t_level'(tgt);
                end
                tgt = latched_target;
                if (pos != tgt) begin
                    ramp_active = 1'b1;
                    // arrival clamps to the target, also when the step would pass zero
                    if (stp != 0 && ((pos > tgt && pos <= tgt + stp) ||
                                     (pos < tgt && pos + stp >= tgt))) begin
                        ramp_pos    = t_level'(tgt);
                        ramp_active = 1'b0;
                    end else if (pos > tgt) begin
                        ramp_pos = t_level'(pos - stp);
                    end else begin
                        ramp_pos = t_level'(pos + stp);
                    end
                    reported_limit = ramp_pos;
                end else begin
                    ramp_active = 1'b0;
                end
            end
            limit_q.push_back(reported_limit);
        endfunction

        function void check_result(t_level got);
            t_level want;
            if (limit_q.size() == 0) begin
                flag($sformatf("unexpected result: current_limit %0d", got));
            end else begin
                want = limit_q.pop_front();
                if (got !== want) begin
                    flag($sformatf("current_limit mismatch: expected %0d, actual %0d",
                                   want, got));
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [InDataW-1:0]   i_s_tdata;   // [7:0] temperature_code, [17:8] charge_permille
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OutDataW-1:0]  o_m_tdata;   // [14:0] current_limit
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CfgAddrW-1:0]  paddr;
    logic [CfgDataW-1:0]  pwdata;
    logic [CfgDataW-1:0]  prdata;
    logic                 pready;

    limit_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    // code/charge pairs for the directed part
    int dir_pairs[46] = '{45, 500, 45, 500, 45, 0, 255, 1023,
                          11, 100, 10, 0, 90, 1023, 91, 400, 0, 1000, 20, 101,
                          21, 400, 30, 401, 31, 100, 50, 1000, 51, 99, 60, 100,
                          61, 99, 61, 100, 90, 401, 255, 0,
                          61, 1023, 11, 0,
                          11, 0};
    int code_edges[14]   = '{0, 10, 11, 20, 21, 30, 31, 50, 51, 60, 61, 90, 91, 255};
    int charge_edges[11] = '{0, 99, 100, 101, 399, 400, 401, 999, 1000, 1001, 1023};

    discharge_limit_ramp uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random stalls, check every accepted result
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready) begin
                sb.check_result(o_m_tdata[LevelW-1:0]);
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(t_code code, t_charge charge);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, charge, code};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(code, charge);
    endtask

    task automatic send_directed(int first, int last);
        for (int i = first; i <= last; i++) begin
            send_request(t_code'(dir_pairs[2*i]), t_charge'(dir_pairs[2*i+1]));
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic apb_access(bit wr, logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] wdata,
                              output logic [CfgDataW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only touched with nothing in flight; reads the value back.
    task automatic program_step(t_level value);
        logic [CfgDataW-1:0] rd;
        while (sb.pending() != 0) @(posedge i_clk);
        apb_access(1'b1, RegRampStep, CfgDataW'(value), rd);
        sb.set_step(value);
        @(posedge i_clk);
        apb_access(1'b0, RegRampStep, '0, rd);
        if (rd !== CfgDataW'(value)) begin
            sb.flag($sformatf("ramp_step readback: expected %0d, actual %0d", value, rd));
        end
    endtask

    function automatic t_code pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            return t_code'(code_edges[$urandom_range(13)]);
        end else if (r < 85) begin
            return t_code'($urandom_range(90, 11));
        end
        return t_code'($urandom_range(255));
    endfunction

    function automatic t_charge pick_charge();
        if ($urandom_range(1) == 0) begin
            return t_charge'(charge_edges[$urandom_range(10)]);
        end
        return t_charge'($urandom_range(1023));
    endfunction

    // Runs of repeated requests let the ramp arrive and sit on its target.
    task automatic send_random(int total);
        int     sent;
        int     run_len;
        t_code  code;
        t_charge charge;
        sent = 0;
        while (sent < total) begin
            code    = pick_code();
            charge  = pick_charge();
            run_len = ($urandom_range(9) < 7) ? $urandom_range(4, 1) : $urandom_range(40, 5);
            for (int i = 0; i < run_len && sent < total; i++) begin
                send_request(code, charge);
                sent++;
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic run_phase(int s_idle, int r_idle, t_level step_a, t_level step_b);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        program_step(step_a);
        send_random(65);
        program_step(step_b);
        send_random(65);
    endtask

    initial begin
        logic [CfgDataW-1:0] rd;
        sb = new();
        send_idle_pct = 30;
        recv_idle_pct = 53;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_access(1'b0, RegRampStep, '0, rd);
        if (rd !== CfgDataW'(RampStepReset)) begin
            sb.flag($sformatf("ramp_step after reset: expected %0d, actual %0d",
                              RampStepReset, rd));
        end

        // first request jumps, then equal level, then a slow ramp with a latched target
        send_directed(0, 3);
        // full step: every band edge, clamps from above, from below and through zero
        program_step(15'd24000);
        send_directed(4, 19);
        // zero step holds the level while the ramp stays latched
        program_step(15'd0);
        send_directed(20, 21);
        program_step(15'd5000);
        send_directed(22, 22);

        run_phase(30, 53, t_level'($urandom_range(3000, 200)), t_level'($urandom_range(24000, 1)));
        run_phase(53, 30, 15'd1, t_level'($urandom_range(24000, 1)));
        run_phase(0, 0, 15'd24000, t_level'($urandom_range(8000, 500)));

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("PASS discharge_limit_ramp");
        end else begin
            $display("FAIL discharge_limit_ramp");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL discharge_limit_ramp");
        $finish;
    end

endmodule

`default_nettype wire
